// ===== hdl/srps_pkg.sv =====
package srps_pkg;

    localparam int POSE_SLOTS = 4;
    localparam int JOINTS     = 4;

    localparam int ANGLE_W    = 8;
    localparam int REQ_W      = 2;
    localparam int STORED_W   = 3;
    localparam int PLAY_W     = 2;
    localparam int DWELL_W    = 8;

    localparam int IDX_W      = (POSE_SLOTS > 1) ? $clog2(POSE_SLOTS) : 1;
    localparam int CNT_W      = $clog2(POSE_SLOTS + 1);

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [DWELL_W-1:0] DWELL_RESET = 8'd40;
    localparam logic [ANGLE_W-1:0] HOME_RESET  = 8'd90;

    typedef enum logic [REQ_W-1:0] {
        REQ_SET    = 2'd0,
        REQ_RECORD = 2'd1,
        REQ_TICK   = 2'd2
    } t_req;

    typedef enum logic [0:0] {
        REG_DWELL_TICKS = 1'b0,
        REG_HOME_ANGLE  = 1'b1
    } t_reg_idx;

    typedef logic [ANGLE_W-1:0] t_angle;
    typedef t_angle [JOINTS-1:0] t_pose;

    typedef struct packed {
        t_pose               angles;
        logic                servo_update;
        logic                record_done;
        logic [STORED_W-1:0] poses_stored;
        logic [PLAY_W-1:0]   play_position;
        logic                dwelling;
    } t_result;

endpackage

// ===== hdl/srps_if.sv =====
interface srps_in_if;
    logic                            valid;
    logic                            ready;
    logic [srps_pkg::REQ_W-1:0]      req_type;
    logic [srps_pkg::ANGLE_W-1:0]    angle_a;
    logic [srps_pkg::ANGLE_W-1:0]    angle_b;
    logic [srps_pkg::ANGLE_W-1:0]    angle_c;
    logic [srps_pkg::ANGLE_W-1:0]    angle_d;
    logic                            playback_enable;

    modport source (
        output valid, req_type, angle_a, angle_b, angle_c, angle_d, playback_enable,
        input  ready
    );
    modport sink (
        input  valid, req_type, angle_a, angle_b, angle_c, angle_d, playback_enable,
        output ready
    );
endinterface

interface srps_out_if;
    logic                            valid;
    logic                            ready;
    logic [srps_pkg::ANGLE_W-1:0]    out_angle_a;
    logic [srps_pkg::ANGLE_W-1:0]    out_angle_b;
    logic [srps_pkg::ANGLE_W-1:0]    out_angle_c;
    logic [srps_pkg::ANGLE_W-1:0]    out_angle_d;
    logic                            servo_update;
    logic                            record_done;
    logic [srps_pkg::STORED_W-1:0]   poses_stored;
    logic [srps_pkg::PLAY_W-1:0]     play_position;
    logic                            dwelling;

    modport source (
        output valid, out_angle_a, out_angle_b, out_angle_c, out_angle_d, servo_update,
               record_done, poses_stored, play_position, dwelling,
        input  ready
    );
    modport sink (
        input  valid, out_angle_a, out_angle_b, out_angle_c, out_angle_d, servo_update,
               record_done, poses_stored, play_position, dwelling,
        output ready
    );
endinterface

// ===== hdl/servo_record_playback_sequencer_unit.sv =====
// channel   | dir | handshake     | word
// ----------+-----+---------------+-------------------------------------------
// i_in      | in  | valid / ready | req_type, angle_a..angle_d, playback_enable
// o_out     | out | valid / ready | out_angle_a..d, flags, counts, play index
// apb       | in  | psel, penable | dwell_ticks @ 0x0, home_angle @ 0x4
//
// one word per cycle while the skid entry is free: the request is decoded and the
// joint, store and playback registers update in the accepting cycle; the result is
// held in an output register backed by one skid entry
// i_rst_n is synchronous; joints return to 90, counts and indices to zero,
// dwell_ticks to 40 and home_angle to 90; recorded poses are not cleared
// input ready drops only while both output entries are full
module servo_record_playback_sequencer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    srps_in_if.sink                             i_in,
    srps_out_if.source                          o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [srps_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [srps_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [srps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import srps_pkg::*;

    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(POSE_SLOTS);

    logic [DWELL_W-1:0] r_dwell_ticks;
    logic [ANGLE_W-1:0] r_home;

    t_pose              r_joint, n_joint;
    t_pose              r_store [POSE_SLOTS];
    logic [IDX_W-1:0]   r_wr, n_wr;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [IDX_W-1:0]   r_play, n_play;
    logic [DWELL_W-1:0] r_dcnt, n_dcnt;
    logic               r_dwell, n_dwell;

    t_result            r_out, r_skid, n_res;
    logic               r_out_vld, r_skid_vld;

    logic               accept, pop, cfg_wr;
    logic               upd, rec, st_we;
    logic [IDX_W-1:0]   w_idx, pidx;
    logic [CNT_W-1:0]   winc, pinc;
    logic [DWELL_W-1:0] dinc;
    t_pose              target, stepped;
    t_pose              in_pose;

    assign accept = i_in.valid && i_in.ready;
    assign pop    = r_out_vld && o_out.ready;
    assign i_in.ready = !r_skid_vld;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    assign in_pose = {i_in.angle_d, i_in.angle_c, i_in.angle_b, i_in.angle_a};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dwell_ticks <= DWELL_RESET;
            r_home        <= HOME_RESET;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_DWELL_TICKS: r_dwell_ticks <= pwdata[DWELL_W-1:0];
                REG_HOME_ANGLE:  r_home        <= pwdata[ANGLE_W-1:0];
                default:         r_home        <= r_home;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (t_reg_idx'(paddr[2]))
            REG_DWELL_TICKS: prdata = APB_DATA_W'(r_dwell_ticks);
            REG_HOME_ANGLE:  prdata = APB_DATA_W'(r_home);
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        w_idx = (CNT_W'(r_wr) >= SLOTS_C) ? '0 : r_wr;
        winc  = CNT_W'(w_idx) + CNT_W'(1);
        pidx  = (CNT_W'(r_play) >= r_cnt) ? '0 : r_play;
        pinc  = CNT_W'(pidx) + CNT_W'(1);
        dinc  = r_dcnt + DWELL_W'(1);
        target = r_store[pidx];
        for (int j = 0; j < JOINTS; j++) begin
            if (r_joint[j] < target[j]) begin
                stepped[j] = r_joint[j] + ANGLE_W'(1);
            end else if (r_joint[j] > target[j]) begin
                stepped[j] = r_joint[j] - ANGLE_W'(1);
            end else begin
                stepped[j] = r_joint[j];
            end
        end
    end

    always_comb begin
        n_joint = r_joint;
        n_wr    = r_wr;
        n_cnt   = r_cnt;
        n_play  = r_play;
        n_dcnt  = r_dcnt;
        n_dwell = r_dwell;
        upd     = 1'b0;
        rec     = 1'b0;
        st_we   = 1'b0;
        case (t_req'(i_in.req_type))
            REQ_SET: begin
                n_joint = in_pose;
                upd     = 1'b1;
            end
            REQ_RECORD: begin
                st_we = 1'b1;
                rec   = 1'b1;
                n_wr  = (winc >= SLOTS_C) ? '0 : winc[IDX_W-1:0];
                if (r_cnt < SLOTS_C) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            REQ_TICK: begin
                if (!i_in.playback_enable) begin
                    n_dwell = 1'b0;
                    n_dcnt  = '0;
                end else if (r_cnt == '0) begin
                    for (int j = 0; j < JOINTS; j++) begin
                        n_joint[j] = r_home;
                    end
                    n_dwell = 1'b0;
                    n_dcnt  = '0;
                    upd     = 1'b1;
                end else if (r_dwell) begin
                    n_play = pidx;
                    n_dcnt = dinc;
                    if (dinc >= r_dwell_ticks) begin
                        n_play  = (pinc >= r_cnt) ? '0 : pinc[IDX_W-1:0];
                        n_dwell = 1'b0;
                        n_dcnt  = '0;
                    end
                end else begin
                    n_play  = pidx;
                    n_joint = stepped;
                    upd     = (r_joint != target);
                    if (stepped == target) begin
                        n_dwell = 1'b1;
                        n_dcnt  = '0;
                    end
                end
            end
            default: begin
                upd = 1'b0;
            end
        endcase

        n_res.angles        = n_joint;
        n_res.servo_update  = upd;
        n_res.record_done   = rec;
        n_res.poses_stored  = STORED_W'(n_cnt);
        n_res.play_position = PLAY_W'(n_play);
        n_res.dwelling      = n_dwell;
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < JOINTS; j++) begin
                r_joint[j] <= HOME_RESET;
            end
            r_wr    <= '0;
            r_cnt   <= '0;
            r_play  <= '0;
            r_dcnt  <= '0;
            r_dwell <= 1'b0;
        end else if (accept) begin
            r_joint <= n_joint;
            r_wr    <= n_wr;
            r_cnt   <= n_cnt;
            r_play  <= n_play;
            r_dcnt  <= n_dcnt;
            r_dwell <= n_dwell;
        end
    end

    // pose store
    always_ff @(posedge i_clk) begin
        if (accept && st_we) begin
            r_store[w_idx] <= r_joint;
        end
    end

    // output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (pop) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= accept;
            end
        end else if (accept) begin
            if (r_out_vld) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= n_res;
            end
        end else if (accept) begin
            if (r_out_vld) begin
                r_skid <= n_res;
            end else begin
                r_out  <= n_res;
            end
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.out_angle_a   = r_out.angles[0];
    assign o_out.out_angle_b   = r_out.angles[1];
    assign o_out.out_angle_c   = r_out.angles[2];
    assign o_out.out_angle_d   = r_out.angles[3];
    assign o_out.servo_update  = r_out.servo_update;
    assign o_out.record_done   = r_out.record_done;
    assign o_out.poses_stored  = r_out.poses_stored;
    assign o_out.play_position = r_out.play_position;
    assign o_out.dwelling      = r_out.dwelling;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import srps_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    class joint_scoreboard;
        t_pose              joints;
        t_pose              taught [POSE_SLOTS];
        logic [IDX_W-1:0]   write_idx;
        logic [CNT_W-1:0]   taught_count;
        logic [IDX_W-1:0]   play_idx;
        logic [DWELL_W-1:0] hold_count;
        logic               holding;
        logic [DWELL_W-1:0] hold_ticks;
        t_angle             home;
        t_result            expected_poses [$];
        int                 checked;
        int                 errors;
        int                 reported;

        function new();
            joints       = {JOINTS{HOME_RESET}};
            write_idx    = '0;
            taught_count = '0;
            play_idx     = '0;
            hold_count   = '0;
            holding      = 1'b0;
            hold_ticks   = DWELL_RESET;
            home         = HOME_RESET;
            checked      = 0;
            errors       = 0;
            reported     = 0;
        endfunction

        function int pending();
            return expected_poses.size();
        endfunction

        // works out the word the block returns for one accepted request
        function void note_word(logic [REQ_W-1:0] req, t_pose ang, logic en);
            t_result r;
            t_pose   tgt;
            logic    upd;
            logic    rec;
            int      j;
            upd = 1'b0;
            rec = 1'b0;
            case (req)
                REQ_SET: begin
                    joints = ang;
                    upd    = 1'b1;
                end
                REQ_RECORD: begin
                    taught[write_idx] = joints;
                    write_idx = (write_idx == POSE_SLOTS - 1) ? '0 : write_idx + 1'b1;
                    if (taught_count < POSE_SLOTS)
                        taught_count = taught_count + 1'b1;
                    rec = 1'b1;
                end
                REQ_TICK: begin
                    if (!en) begin
                        holding    = 1'b0;
                        hold_count = '0;
                    end else if (taught_count == 0) begin
                        joints     = {JOINTS{home}};
                        holding    = 1'b0;
                        hold_count = '0;
                        upd        = 1'b1;
                    end else begin
                        if (play_idx >= taught_count)
                            play_idx = '0;
                        if (holding) begin
                            hold_count = hold_count + 1'b1;
                            if (hold_count >= hold_ticks) begin
                                play_idx   = (play_idx + 1 >= taught_count) ?
                                             '0 : play_idx + 1'b1;
                                holding    = 1'b0;
                                hold_count = '0;
                            end
                        end else begin
                            tgt = taught[play_idx];
                            if (joints != tgt) begin
                                for (j = 0; j < JOINTS; j++) begin
                                    if (joints[j] < tgt[j])
                                        joints[j] = joints[j] + 1'b1;
                                    else if (joints[j] > tgt[j])
                                        joints[j] = joints[j] - 1'b1;
                                end
                                upd = 1'b1;
                            end
                            if (joints == tgt) begin
                                holding    = 1'b1;
                                hold_count = '0;
                            end
                        end
                    end
                end
                default: ;
            endcase
            r.angles        = joints;
            r.servo_update  = upd;
            r.record_done   = rec;
            r.poses_stored  = taught_count;
            r.play_position = play_idx;
            r.dwelling      = holding;
            expected_poses.push_back(r);
        endfunction

        function void check_word(t_result got);
            t_result want;
            if (expected_poses.size() == 0) begin
                errors++;
                if (reported < 10)
                    $display("unexpected result word %h with nothing outstanding", got);
                reported++;
                return;
            end
            want = expected_poses.pop_front();
            checked++;
            if (got.angles !== want.angles || got.servo_update !== want.servo_update ||
                got.record_done !== want.record_done ||
                got.poses_stored !== want.poses_stored ||
                got.play_position !== want.play_position ||
                got.dwelling !== want.dwelling) begin
                errors++;
                if (reported < 10)
                    $display({"mismatch on result %0d: expected angles %h upd %b rec %b ",
                              "stored %0d play %0d dwell %b, got angles %h upd %b rec %b ",
                              "stored %0d play %0d dwell %b"},
                             checked, want.angles, want.servo_update, want.record_done,
                             want.poses_stored, want.play_position, want.dwelling,
                             got.angles, got.servo_update, got.record_done,
                             got.poses_stored, got.play_position, got.dwelling);
                reported++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    srps_in_if  in_word ();
    srps_out_if out_word ();

    joint_scoreboard sb = new();

    int   words_sent = 0;
    int   settings_written = 0;
    logic no_idle;

    assign no_idle = (words_sent >= 700) && (words_sent < 1000);

    servo_record_playback_sequencer_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_word),
        .o_out   (out_word),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        out_word.ready <= no_idle || ($urandom_range(0, 99) >= 26);
    end

    always @(posedge i_clk) begin : watch_results
        t_result got;
        if (i_rst_n && out_word.valid && out_word.ready) begin
            got.angles        = {out_word.out_angle_d, out_word.out_angle_c,
                                 out_word.out_angle_b, out_word.out_angle_a};
            got.servo_update  = out_word.servo_update;
            got.record_done   = out_word.record_done;
            got.poses_stored  = out_word.poses_stored;
            got.play_position = out_word.play_position;
            got.dwelling      = out_word.dwelling;
            sb.check_word(got);
        end
    end

    // angle a is the low byte of a pose
    task automatic send_word(logic [REQ_W-1:0] req, t_pose ang, logic en);
        while (!no_idle && $urandom_range(0, 99) < 26) begin
            in_word.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_word.valid           <= 1'b1;
        in_word.req_type        <= req;
        in_word.angle_a         <= ang[0];
        in_word.angle_b         <= ang[1];
        in_word.angle_c         <= ang[2];
        in_word.angle_d         <= ang[3];
        in_word.playback_enable <= en;
        @(posedge i_clk);
        while (!in_word.ready)
            @(posedge i_clk);
        sb.note_word(req, ang, en);
        words_sent++;
    endtask

    task automatic wait_drained();
        in_word.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_register(t_reg_idx idx, logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_DWELL_TICKS: sb.hold_ticks = value;
            REG_HOME_ANGLE:  sb.home = value;
            default: ;
        endcase
        settings_written++;
        @(posedge i_clk);
    endtask

    function automatic t_angle near(t_angle base);
        int off;
        int v;
        off = $urandom_range(0, 12);
        v   = int'(base) + off - 6;
        if (v < 0)
            v = 0;
        else if (v > 255)
            v = 255;
        return t_angle'(v);
    endfunction

    // teach a few nearby poses, then replay them with some noise mixed in
    task automatic run_phase(int budget);
        int     stop;
        int     k;
        int     m;
        int     p;
        int     j;
        t_angle base;
        t_pose  ang;
        stop = words_sent + budget;
        while (words_sent < stop) begin
            case ($urandom_range(0, 5))
                0:       base = 8'd0;
                1:       base = 8'd255;
                default: base = t_angle'($urandom_range(0, 255));
            endcase
            k = $urandom_range(1, 5);
            repeat (k) begin
                for (j = 0; j < JOINTS; j++)
                    ang[j] = near(base);
                send_word(REQ_SET, ang, 1'($urandom_range(0, 1)));
                send_word(REQ_RECORD, t_pose'($urandom), 1'($urandom_range(0, 1)));
            end
            m = $urandom_range(10, 40) + int'(sb.hold_ticks) * $urandom_range(1, 2);
            repeat (m) begin
                p = $urandom_range(0, 99);
                if (p < 6)
                    send_word(REQ_TICK, t_pose'($urandom), 1'b0);
                else if (p < 10)
                    send_word(REQ_W'($urandom_range(0, 3)), t_pose'($urandom),
                              1'($urandom_range(0, 1)));
                else
                    send_word(REQ_TICK, t_pose'($urandom), 1'b1);
            end
        end
    endtask

    initial begin
        int         ph;
        int         bud;
        logic [7:0] dw;
        logic [7:0] hm;
        i_rst_n                 <= 1'b0;
        in_word.valid           <= 1'b0;
        in_word.req_type        <= REQ_SET;
        in_word.angle_a         <= '0;
        in_word.angle_b         <= '0;
        in_word.angle_c         <= '0;
        in_word.angle_d         <= '0;
        in_word.playback_enable <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= '0;
        pwdata                  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing recorded yet: home angle, abort and the unused code
        send_word(REQ_TICK, t_pose'($urandom), 1'b1);
        send_word(REQ_TICK, t_pose'($urandom), 1'b0);
        send_word(REQ_UNUSED, t_pose'($urandom), 1'b1);
        wait_drained();
        set_register(REG_HOME_ANGLE, 8'd0);
        set_register(REG_DWELL_TICKS, 8'd1);
        send_word(REQ_TICK, t_pose'($urandom), 1'b1);
        wait_drained();
        set_register(REG_HOME_ANGLE, 8'd255);
        send_word(REQ_TICK, t_pose'($urandom), 1'b1);

        // one pose: walk in, dwell, wrap the play index, abort
        send_word(REQ_SET, 32'h00000000, 1'b0);
        send_word(REQ_RECORD, t_pose'($urandom), 1'b1);
        send_word(REQ_SET, 32'h02000201, 1'b1);
        repeat (4) send_word(REQ_TICK, t_pose'($urandom), 1'b1);
        send_word(REQ_TICK, t_pose'($urandom), 1'b0);

        // store wraps and the count saturates
        send_word(REQ_SET, 32'hFFFFFFFF, 1'b0);
        repeat (4) send_word(REQ_RECORD, t_pose'($urandom), 1'b0);
        send_word(REQ_SET, 32'h80FF00FE, 1'b1);
        repeat (2) send_word(REQ_TICK, t_pose'($urandom), 1'b1);
        send_word(REQ_SET, 32'h01FF0080, 1'b1);
        send_word(REQ_UNUSED, t_pose'($urandom), 1'b0);
        send_word(REQ_TICK, t_pose'($urandom), 1'b0);
        send_word(REQ_TICK, t_pose'($urandom), 1'b1);

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin dw = 8'd3;   hm = 8'd0;   bud = 300; end
                1: begin dw = 8'd1;   hm = 8'd255; bud = 300; end
                2: begin dw = 8'd255; hm = 8'd128; bud = 300; end
                default: begin
                    dw  = 8'($urandom_range(2, 8));
                    hm  = 8'($urandom);
                    bud = 250;
                end
            endcase
            wait_drained();
            set_register(REG_DWELL_TICKS, dw);
            set_register(REG_HOME_ANGLE, hm);
            run_phase(bud);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("covered %0d request words, %0d results compared, %0d register writes",
                 words_sent, sb.checked, settings_written);
        $display("mismatched or unexpected results: %0d", sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("run timed out");
        $display("FAILED: results differ");
        $finish;
    end

endmodule
